/* rtl/core/usr_pkg.sv */
// Package for the ultrasonic ranger with stop confirmation.
// Holds shared types, phase and status codes and the divide-by-58 constants.
// No dependencies.
package usr_pkg;

    localparam int unsigned TICK_W = 20;
    localparam int unsigned CNT_W  = TICK_W + 1;

    typedef enum logic [5:0] {
        PH_SETTLE = 6'b000001,
        PH_TRIG   = 6'b000010,
        PH_RISE   = 6'b000100,
        PH_HIGH   = 6'b001000,
        PH_IDLE   = 6'b010000,
        PH_HALT   = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_STOP     = 2'd1;
    localparam logic [1:0] CFG_CONFIRM  = 2'd2;
    localparam logic [1:0] CFG_INTERVAL = 2'd3;

    // echo widths giving 2..400 cm (58 ticks per cm)
    localparam logic [CNT_W-1:0] MIN_WIDTH = CNT_W'(2 * 58);
    localparam logic [CNT_W-1:0] MAX_WIDTH = CNT_W'(401 * 58);

    // floor(w / 58) = floor((w >> 1) * RECIP >> SHIFT) for w < MAX_WIDTH
    localparam int unsigned HALF_W  = 14;
    localparam int unsigned RECIP_W = 15;
    localparam int unsigned PROD_W  = HALF_W + RECIP_W;
    localparam int unsigned SHIFT   = 19;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(18079);

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [8:0]  stop_distance_cm;
        logic [7:0]  confirm_count;
        logic [19:0] interval_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic [TICK_W-1:0] tick_count;
        logic [7:0]        close_count;
        logic [15:0]       pot_index;
    } t_state;

    typedef struct packed {
        logic        trigger_level;
        logic        reading_valid;
        logic [10:0] distance_cm;
        t_status     reading_status;
        logic        capture_req;
        logic [15:0] pot_number;
        logic        waiting_done;
    } t_res;

endpackage

/* rtl/core/usr_step.sv */
// Per-tick next-state and result logic of the ultrasonic ranger.
// Depends on usr_pkg.
module usr_step
    import usr_pkg::*;
#(
    parameter int unsigned SETTLE_LOW_TICKS   = 5,
    parameter int unsigned TRIGGER_HIGH_TICKS = 10
) (
    input  t_state i_state,
    input  t_cfg   i_cfg,
    input  logic   i_echo,
    input  logic   i_done,
    output t_state o_next,
    output t_res   o_res
);

    localparam logic [CNT_W-1:0] L_SETTLE = CNT_W'(SETTLE_LOW_TICKS);
    localparam logic [CNT_W-1:0] L_TRIG   = CNT_W'(TRIGGER_HIGH_TICKS);

    logic [CNT_W-1:0]  elapsed;
    logic              timed_out;
    logic              out_of_range;
    logic [HALF_W-1:0] half;
    logic [PROD_W-1:0] prod;
    logic [8:0]        quot_cm;
    logic              fin;
    t_status           fin_status;
    logic [8:0]        fin_dist;
    logic              close;
    logic [7:0]        close_inc;
    t_phase            rest_phase;

    always_comb begin
        elapsed      = {1'b0, i_state.tick_count} + CNT_W'(1);
        timed_out    = elapsed > CNT_W'(i_cfg.timeout_ticks);
        out_of_range = (elapsed < MIN_WIDTH) || (elapsed >= MAX_WIDTH);
        half         = elapsed[HALF_W:1];
        prod         = PROD_W'(half) * PROD_W'(RECIP);
        quot_cm      = prod[SHIFT +: 9];
        rest_phase   = (i_cfg.interval_ticks == '0) ? PH_SETTLE : PH_IDLE;

        o_next            = i_state;
        o_res             = '0;
        o_res.pot_number  = i_state.pot_index;
        fin               = 1'b0;
        fin_status        = ST_OK;
        fin_dist          = '0;
        close             = 1'b0;
        close_inc         = '0;

        unique case (i_state.phase)
            PH_SETTLE: begin
                o_next.tick_count = elapsed[TICK_W-1:0];
                if (elapsed >= L_SETTLE) begin
                    o_next.tick_count = '0;
                    o_next.phase      = PH_TRIG;
                end
            end
            PH_TRIG: begin
                o_res.trigger_level = 1'b1;
                o_next.tick_count   = elapsed[TICK_W-1:0];
                if (elapsed >= L_TRIG) begin
                    o_next.tick_count = '0;
                    o_next.phase      = PH_RISE;
                end
            end
            PH_RISE: begin
                if (i_echo) begin
                    o_next.tick_count = '0;
                    o_next.phase      = PH_HIGH;
                end else if (timed_out) begin
                    fin        = 1'b1;
                    fin_status = ST_TIMEOUT;
                end else begin
                    o_next.tick_count = elapsed[TICK_W-1:0];
                end
            end
            PH_HIGH: begin
                if (!i_echo) begin
                    fin = 1'b1;
                    if (out_of_range) begin
                        fin_status = ST_RANGE;
                    end else begin
                        fin_dist = quot_cm;
                    end
                end else if (timed_out) begin
                    fin        = 1'b1;
                    fin_status = ST_TIMEOUT;
                end else begin
                    o_next.tick_count = elapsed[TICK_W-1:0];
                end
            end
            PH_IDLE: begin
                o_next.tick_count = elapsed[TICK_W-1:0];
                if (elapsed >= CNT_W'(i_cfg.interval_ticks)) begin
                    o_next.tick_count = '0;
                    o_next.phase      = PH_SETTLE;
                end
            end
            PH_HALT: begin
                o_res.waiting_done = 1'b1;
                if (i_done) begin
                    o_next.pot_index   = i_state.pot_index + 16'd1;
                    o_next.close_count = '0;
                    o_next.tick_count  = '0;
                    o_next.phase       = PH_SETTLE;
                end
            end
            default: begin
                o_next.tick_count = '0;
                o_next.phase      = PH_SETTLE;
            end
        endcase

        if (fin) begin
            o_res.reading_valid  = 1'b1;
            o_res.reading_status = fin_status;
            o_res.distance_cm    = 11'(fin_dist);
            o_next.tick_count    = '0;
            close = (fin_status == ST_OK) && (fin_dist < i_cfg.stop_distance_cm);
            if (close) begin
                close_inc = (i_state.close_count == 8'hFF) ? 8'hFF
                                                           : i_state.close_count + 8'd1;
                o_next.close_count = close_inc;
                if (close_inc >= i_cfg.confirm_count) begin
                    o_res.capture_req = 1'b1;
                    o_next.phase      = PH_HALT;
                end else begin
                    o_next.phase = rest_phase;
                end
            end else begin
                o_next.close_count = '0;
                o_next.phase       = rest_phase;
            end
        end
    end

endmodule

/* rtl/core/ultrasonic_range_with_stop_confirm.sv */
// Top level of the ultrasonic ranger with stop confirmation.
// Depends on usr_pkg and usr_step.
//
// One request is one microsecond tick and gives exactly one result. A request
// is taken every cycle unless the input stalls; its result is registered in the
// output register. A one-entry skid stage behind the output register lets the
// block take one more request while a result is stalled; the input stalls only
// when the skid stage is full. The ranging sequence (settle, trigger, echo
// rise, echo width, idle or halt for the camera) advances one step per request,
// and the echo width is divided by 58 with a short reciprocal multiply in the
// same cycle. The user must write configuration registers through the plain
// write port only while no request is outstanding; the block does not enforce it.
module ultrasonic_range_with_stop_confirm
    import usr_pkg::*;
#(
    parameter int unsigned SETTLE_LOW_TICKS   = 5,
    parameter int unsigned TRIGGER_HIGH_TICKS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_echo_level,
    input  logic        i_done_received,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_trigger_level,
    output logic        o_reading_valid,
    output logic [10:0] o_distance_cm,
    output logic [1:0]  o_reading_status,
    output logic        o_capture_req,
    output logic [15:0] o_pot_number,
    output logic        o_waiting_done
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_res   n_res;
    t_res   r_out;
    t_res   r_skid;
    logic   r_out_valid;
    logic   r_skid_valid;
    logic   in_acc;
    logic   out_take;

    usr_step #(
        .SETTLE_LOW_TICKS   (SETTLE_LOW_TICKS),
        .TRIGGER_HIGH_TICKS (TRIGGER_HIGH_TICKS)
    ) u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_echo  (i_echo_level),
        .i_done  (i_done_received),
        .o_next  (n_state),
        .o_res   (n_res)
    );

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks    <= 16'd30000;
            r_cfg.stop_distance_cm <= 9'd5;
            r_cfg.confirm_count    <= 8'd3;
            r_cfg.interval_ticks   <= 20'd200000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT:  r_cfg.timeout_ticks    <= i_cfg_data[15:0];
                CFG_STOP:     r_cfg.stop_distance_cm <= i_cfg_data[8:0];
                CFG_CONFIRM:  r_cfg.confirm_count    <= i_cfg_data[7:0];
                CFG_INTERVAL: r_cfg.interval_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_SETTLE;
            r_state.tick_count  <= '0;
            r_state.close_count <= '0;
            r_state.pot_index   <= 16'd1;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_acc && r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else if (out_take && r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end
            if (in_acc || r_skid_valid) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && r_out_valid && !out_take) begin
            r_skid <= n_res;
        end
        if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end else if (in_acc && (!r_out_valid || out_take)) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_trigger_level  = r_out.trigger_level;
    assign o_reading_valid  = r_out.reading_valid;
    assign o_distance_cm    = r_out.distance_cm;
    assign o_reading_status = r_out.reading_status;
    assign o_capture_req    = r_out.capture_req;
    assign o_pot_number     = r_out.pot_number;
    assign o_waiting_done   = r_out.waiting_done;

    a_capture_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.capture_req) |->
            (r_out.reading_valid && r_out.reading_status == ST_OK))
        else $error("capture request without an ok reading");

    a_halt_no_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.waiting_done && r_out.trigger_level))
        else $error("trigger driven while halted");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output entry");

    a_pot_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state.phase == PH_HALT && i_done_received) |=>
            (r_state.pot_index == $past(r_state.pot_index) + 16'd1))
        else $error("pot number did not advance on release");

    a_close_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_res.reading_valid && n_res.reading_status != ST_OK) |=>
            (r_state.close_count == '0))
        else $error("close count kept after a failed reading");

endmodule
